@@ hw/rtl/lor_pkg.sv @@
// Shared constants and types for the largest ones rectangle block.
`timescale 1ns / 1ps
package lor_pkg;
    localparam int MAX_COLS_DEF = 256;
    localparam int MAX_ROWS_DEF = 256;
    localparam int DIM_W        = 9;
    localparam int RUN_W        = 9;
    localparam int AREA_W       = 17;
    localparam logic [RUN_W-1:0]  RUN_MAX  = '1;
    localparam logic [AREA_W-1:0] AREA_MAX = '1;
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // word passed from front to back: pixel, row/frame end marks, clamped column
    typedef struct packed {
        logic             pixel;
        logic             row_end;
        logic             frame_end;
        logic [DIM_W-1:0] col;
    } t_cmd;
endpackage

@@ hw/rtl/lor_front.sv @@
// Front end: accepts pixels, tracks column and row position, tags row and frame ends.
`timescale 1ns / 1ps
module lor_front #(
    parameter int MAX_COLS = lor_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lor_pkg::MAX_ROWS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [lor_pkg::DIM_W-1:0] i_width,
    input  logic [lor_pkg::DIM_W-1:0] i_height,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_pixel,
    output logic                     o_valid,
    input  logic                     i_ready,
    output lor_pkg::t_cmd            o_cmd
);
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int EW = 14;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [EW-1:0] w_cl, h_cl, c_cl, col_e, row_e;
    logic          row_end, frame_end, fire;

    always_comb begin
        w_cl = EW'(i_width);
        h_cl = EW'(i_height);
        if (w_cl == '0) w_cl = EW'(1);
        if (w_cl > EW'(MAX_COLS)) w_cl = EW'(MAX_COLS);
        if (h_cl == '0) h_cl = EW'(1);
        if (h_cl > EW'(MAX_ROWS)) h_cl = EW'(MAX_ROWS);
        // a column past a shrunken width lands on the last column
        c_cl      = (EW'(r_col) < w_cl) ? EW'(r_col) : w_cl - EW'(1);
        col_e     = c_cl + EW'(1);
        row_e     = EW'(r_row) + EW'(1);
        row_end   = col_e >= w_cl;
        frame_end = row_end && (row_e >= h_cl);
        fire      = i_valid && o_ready;
        n_col = r_col;
        n_row = r_row;
        if (fire) begin
            if (row_end) begin
                n_col = '0;
                n_row = frame_end ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    assign o_ready = i_ready;
    assign o_valid = i_valid;
    assign o_cmd   = '{pixel: i_pixel, row_end: row_end, frame_end: frame_end,
                       col: lor_pkg::DIM_W'(c_cl)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end
endmodule

@@ hw/rtl/lor_fifo.sv @@
// Short queue between front and back.
`timescale 1ns / 1ps
module lor_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lor_pkg::t_cmd i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output lor_pkg::t_cmd o_data
);
    lor_pkg::t_cmd r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       wr, rd;

    assign o_ready = r_cnt != 3'd4;
    assign o_valid = r_cnt != 3'd0;
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 2'd1;
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(wr) - 3'(rd);
        end
    end
endmodule

@@ hw/rtl/lor_back.sv @@
// Back end: column runs, two stack passes per row, best area and result register.
`timescale 1ns / 1ps
module lor_back #(
    parameter int MAX_COLS = lor_pkg::MAX_COLS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  lor_pkg::t_cmd              i_cmd,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [lor_pkg::AREA_W-1:0] o_area
);
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NW = $clog2(MAX_COLS + 1);
    localparam int RUN_W = lor_pkg::RUN_W;
    localparam int AREA_W = lor_pkg::AREA_W;

    typedef enum logic [2:0] {
        S_PIX, S_RD, S_RUNW, S_LRD, S_LPOP, S_RRD, S_RPOP, S_CLR
    } t_state;

    t_state r_state;
    logic [RUN_W-1:0] r_run  [MAX_COLS];
    logic [NW-1:0]    r_left [MAX_COLS];
    logic [RUN_W-1:0] r_sh   [MAX_COLS];
    logic [CW-1:0]    r_sc   [MAX_COLS];
    logic [MAX_COLS-1:0] r_vld;
    logic [CW-1:0] r_wcol, r_j;
    logic [NW-1:0] r_w, r_sp, r_lb;
    logic [RUN_W-1:0] r_h, r_rd_run, r_top_h;
    logic [CW-1:0]    r_top_c;
    logic [AREA_W-1:0] r_best, r_area;
    logic r_pix, r_rowe, r_frme, r_ov;
    logic [NW+RUN_W-1:0] prod;
    logic [NW-1:0] span, right;

    assign o_ready = (r_state == S_PIX);
    assign o_valid = r_ov;
    assign o_area  = r_area;
    assign right   = (r_sp == '0) ? r_w : NW'(r_top_c);
    assign span    = right - r_lb - NW'(1);
    assign prod    = NW'(span) * (NW+RUN_W)'(r_h);

    always_ff @(posedge i_clk) begin
        // runs and scratch stores
        case (r_state)
            S_RD: r_rd_run <= r_vld[r_wcol] ? r_run[r_wcol] : '0;
            S_RUNW: r_run[r_wcol] <= !r_pix ? '0 :
                (r_rd_run == lor_pkg::RUN_MAX) ? r_rd_run : r_rd_run + RUN_W'(1);
            S_LRD, S_RRD: begin
                r_h <= r_vld[r_j] ? r_run[r_j] : '0;
                if (r_state == S_RRD) r_lb <= r_left[r_j];
                r_top_h <= r_sh[CW'(r_sp - NW'(1))];
                r_top_c <= r_sc[CW'(r_sp - NW'(1))];
            end
            S_LPOP, S_RPOP: begin
                if (r_sp != '0 && r_top_h >= r_h) begin
                    r_top_h <= r_sh[CW'(r_sp - NW'(2))];
                    r_top_c <= r_sc[CW'(r_sp - NW'(2))];
                end else begin
                    r_sh[CW'(r_sp)] <= r_h;
                    r_sc[CW'(r_sp)] <= r_j;
                    if (r_state == S_LPOP)
                        r_left[r_j] <= (r_sp == '0) ? '1 : NW'(r_top_c);
                end
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            r_state <= S_PIX;
            r_vld <= '0;
            r_best <= '0;
            r_ov <= 1'b0;
            r_sp <= '0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_state)
                S_PIX: if (i_valid && o_ready) begin
                    r_pix <= i_cmd.pixel;
                    r_rowe <= i_cmd.row_end;
                    r_frme <= i_cmd.frame_end;
                    r_wcol <= CW'(i_cmd.col);
                    r_state <= S_RD;
                end
                S_RD: r_state <= S_RUNW;
                S_RUNW: begin
                    r_vld[r_wcol] <= 1'b1;
                    if (r_rowe) begin
                        r_w <= NW'(r_wcol) + NW'(1);
                        r_j <= '0;
                        r_sp <= '0;
                        r_state <= S_LRD;
                    end else begin
                        r_state <= S_PIX;
                    end
                end
                S_LRD: r_state <= S_LPOP;
                S_LPOP: begin
                    if (r_sp != '0 && r_top_h >= r_h) begin
                        r_sp <= r_sp - NW'(1);
                    end else begin
                        r_sp <= r_sp + NW'(1);
                        if (NW'(r_j) + NW'(1) == r_w) begin
                            r_sp <= '0;
                            r_state <= S_RRD;
                        end else begin
                            r_j <= r_j + CW'(1);
                            r_state <= S_LRD;
                        end
                    end
                end
                S_RRD: r_state <= S_RPOP;
                S_RPOP: begin
                    if (r_sp != '0 && r_top_h >= r_h) begin
                        r_sp <= r_sp - NW'(1);
                    end else begin
                        r_sp <= r_sp + NW'(1);
                        if (prod > (NW+RUN_W)'(r_best))
                            r_best <= (prod > (NW+RUN_W)'(lor_pkg::AREA_MAX)) ?
                                      lor_pkg::AREA_MAX : AREA_W'(prod);
                        if (r_j == '0) begin
                            r_state <= r_frme ? S_CLR : S_PIX;
                        end else begin
                            r_j <= r_j - CW'(1);
                            r_state <= S_RRD;
                        end
                    end
                end
                // waits here while the previous result word is still held
                S_CLR: if (!r_ov || i_ready) begin
                    r_area <= r_best;
                    r_ov <= 1'b1;
                    r_best <= '0;
                    r_vld <= '0;
                    r_state <= S_PIX;
                end
                default: r_state <= S_PIX;
            endcase
        end
    end

    a_one_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> (r_ov && $stable(r_area))) else $error("result overwritten");
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= NW'(MAX_COLS)) else $error("stack overflow");
    a_clr_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR && (!r_ov || i_ready)) |=> (r_vld == '0 && r_best == '0))
        else $error("frame clear");
endmodule

@@ hw/rtl/largest_ones_rectangle.sv @@
// Top level of the largest all-ones rectangle finder.
`timescale 1ns / 1ps
// Pixels arrive row-major, one per word; width and height come from the write port
// (0 acts as 1, oversize as the maximum) and apply to the next pixel accepted. Each
// pixel passes the back-end steps accept, run read and run write before the next is
// taken; at each row end two stack passes run over the row, each column a stack-top
// read and a pop-or-push step that repeats once per pop, the stack top being read
// through a register. After each frame's last pixel a clear step loads the result
// word with the best area; it waits while an earlier one is held, and pixels queue.
module largest_ones_rectangle #(
    parameter int MAX_COLS = lor_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lor_pkg::MAX_ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [lor_pkg::DIM_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_pixel,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [lor_pkg::AREA_W-1:0]  o_max_area
);
    logic [lor_pkg::DIM_W-1:0] r_width, r_height;
    logic f_v, f_r, q_v, q_r;
    lor_pkg::t_cmd f_cmd, q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= lor_pkg::DIM_W'(256);
            r_height <= lor_pkg::DIM_W'(256);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == lor_pkg::CFG_WIDTH) r_width <= i_cfg_data;
            else r_height <= i_cfg_data;
        end
    end

    lor_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
        .i_clk, .i_rst_n, .i_width(r_width), .i_height(r_height),
        .i_valid, .o_ready, .i_pixel,
        .o_valid(f_v), .i_ready(f_r), .o_cmd(f_cmd)
    );

    lor_fifo u_fifo (
        .i_clk, .i_rst_n, .i_valid(f_v), .o_ready(f_r), .i_data(f_cmd),
        .o_valid(q_v), .i_ready(q_r), .o_data(q_cmd)
    );

    lor_back #(.MAX_COLS(MAX_COLS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_v), .o_ready(q_r), .i_cmd(q_cmd),
        .o_valid, .i_ready, .o_area(o_max_area)
    );
endmodule
